[src/rhsv_pkg.sv]
package rhsv_pkg;

	localparam int CHAN_W = 8;
	localparam int HUE_W  = 15;
	localparam int SAT_W  = 13;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [HUE_W-1:0]  hue_t;
	typedef logic [SAT_W-1:0]  sat_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

	typedef struct packed {
		hue_t  hue;
		logic  hue_defined;
		sat_t  saturation;
		chan_t brightness;
	} hsv_t;

endpackage

[src/rhsv_front.sv]
module rhsv_front #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12,
	parameter int HNW = 17 + HUE_FRAC_BITS,
	parameter int SNW = SAT_FRAC_BITS + 1 + rhsv_pkg::CHAN_W
) (
	input  logic                 clk,
	input  logic                 en,
	input  rhsv_pkg::pix_t       pix,
	output logic [HNW-1:0]       hue_num,
	output rhsv_pkg::chan_t      hue_den,
	output logic [SNW-1:0]       sat_num,
	output rhsv_pkg::chan_t      sat_den,
	output logic                 defined,
	output logic                 max_zero
);

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	rhsv_pkg::chan_t mx;
	rhsv_pkg::chan_t mn;
	sector_t         sector;
	logic signed [8:0] diff;

	rhsv_pkg::chan_t   mx_s1;
	rhsv_pkg::chan_t   d_s1;
	logic signed [8:0] diff_s1;
	sector_t           sector_s1;

	logic signed [11:0] d_ext;
	logic signed [11:0] diff_ext;
	logic signed [11:0] base;
	logic signed [11:0] wrapped;
	logic [10:0]        sextant;
	logic [16:0]        scaled;

	logic [HNW-1:0]  hue_num_s2;
	logic [SNW-1:0]  sat_num_s2;
	rhsv_pkg::chan_t mx_s2;
	rhsv_pkg::chan_t d_s2;
	logic            defined_s2;
	logic            max_zero_s2;

	always_comb begin
		mx = pix.red;
		if (pix.green > mx) begin
			mx = pix.green;
		end
		if (pix.blue > mx) begin
			mx = pix.blue;
		end
		mn = pix.red;
		if (pix.green < mn) begin
			mn = pix.green;
		end
		if (pix.blue < mn) begin
			mn = pix.blue;
		end
		if (pix.red == mx) begin
			sector = SEC_RED;
			diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
		end else if (pix.green == mx) begin
			sector = SEC_GREEN;
			diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
		end else begin
			sector = SEC_BLUE;
			diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1     <= mx;
			d_s1      <= mx - mn;
			diff_s1   <= diff;
			sector_s1 <= sector;
		end
	end

	// The hue numerator is 60 * (sector offset * d + diff), wrapped into [0, 6d).
	always_comb begin
		d_ext    = signed'({4'b0, d_s1});
		diff_ext = 12'(diff_s1);
		case (sector_s1)
			SEC_RED:   base = diff_ext;
			SEC_GREEN: base = (d_ext <<< 1) + diff_ext;
			SEC_BLUE:  base = (d_ext <<< 2) + diff_ext;
			default:   base = diff_ext;
		endcase
		if (base < 0) begin
			wrapped = base + (d_ext <<< 2) + (d_ext <<< 1);
		end else begin
			wrapped = base;
		end
		sextant = wrapped[10:0];
		scaled  = ({6'b0, sextant} << 6) - ({6'b0, sextant} << 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_num_s2  <= HNW'(scaled) << HUE_FRAC_BITS;
			sat_num_s2  <= SNW'(d_s1) << SAT_FRAC_BITS;
			mx_s2       <= mx_s1;
			d_s2        <= d_s1;
			defined_s2  <= (d_s1 != '0);
			max_zero_s2 <= (mx_s1 == '0);
		end
	end

	assign hue_num  = hue_num_s2;
	assign hue_den  = d_s2;
	assign sat_num  = sat_num_s2;
	assign sat_den  = mx_s2;
	assign defined  = defined_s2;
	assign max_zero = max_zero_s2;

endmodule

[src/rhsv_div.sv]
module rhsv_div #(
	parameter int QW = 15,
	parameter int DW = 8,
	parameter int SW = 1,
	parameter int STAGES = 15
) (
	input  logic            clk,
	input  logic            en,
	input  logic [QW+DW-1:0] dividend,
	input  logic [DW-1:0]   divisor,
	input  logic [SW-1:0]   side_in,
	output logic [QW-1:0]   quotient,
	output logic [SW-1:0]   side_out
);

	logic [DW-1:0] rem_s  [STAGES];
	logic [QW-1:0] low_s  [STAGES];
	logic [QW-1:0] quo_s  [STAGES];
	logic [DW-1:0] den_s  [STAGES];
	logic [SW-1:0] side_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] low_in;
		logic [QW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [SW-1:0] side_k;

		if (k == 0) begin : g_first
			assign rem_in = dividend[QW+DW-1:QW];
			assign low_in = dividend[QW-1:0];
			assign quo_in = '0;
			assign den_in = divisor;
			assign side_k = side_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign side_k = side_s[k-1];
		end

		if (k < QW) begin : g_step
			logic [DW:0] trial;
			logic        take;

			assign trial = {rem_in, low_in[QW-1]};
			assign take  = (trial >= {1'b0, den_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
					low_s[k]  <= low_in << 1;
					quo_s[k]  <= {quo_in[QW-2:0], take};
					den_s[k]  <= den_in;
					side_s[k] <= side_k;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= rem_in;
					low_s[k]  <= low_in;
					quo_s[k]  <= quo_in;
					den_s[k]  <= den_in;
					side_s[k] <= side_k;
				end
			end
		end
	end

	assign quotient = quo_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule

[src/rgb_to_hsv_converter.sv]
// Channel  Signals                 Item
// pixel    pix_valid, pix_stall    pix: red, green, blue bytes
// result   hsv_valid, hsv_stall    hsv: hue, hue_defined, saturation, brightness
//
// One pixel is taken every cycle unless pix_stall is high; each result passes
// through the front-end registers and then the two bit-per-stage dividers.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A stalled result holds the whole pipeline, so pix_stall follows hsv_stall while
// a result is waiting; bubbles move on and nothing is lost or repeated.
module rgb_to_hsv_converter #(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  rhsv_pkg::pix_t pix,
	output logic           hsv_valid,
	input  logic           hsv_stall,
	output rhsv_pkg::hsv_t hsv
);

	localparam int CW     = rhsv_pkg::CHAN_W;
	localparam int HQW    = 9 + HUE_FRAC_BITS;
	localparam int SQW    = SAT_FRAC_BITS + 1;
	localparam int STAGES = (HQW > SQW) ? HQW : SQW;
	localparam int DEPTH  = 2 + STAGES;

	logic             en;
	logic [DEPTH-1:0] valid_q;

	logic [HQW+CW-1:0] hue_num;
	logic [CW-1:0]     hue_den;
	logic [SQW+CW-1:0] sat_num;
	logic [CW-1:0]     sat_den;
	logic              defined;
	logic              max_zero;

	logic [HQW-1:0] hue_quo;
	logic [SQW-1:0] sat_quo;
	logic [CW:0]    hue_side;
	logic           sat_side;

	assign en        = !(valid_q[DEPTH-1] && hsv_stall);
	assign pix_stall = !en;
	assign hsv_valid = valid_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[DEPTH-2:0], pix_valid};
		end
	end

	rhsv_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS),
		.HNW(HQW + CW),
		.SNW(SQW + CW)
	) u_front (
		.clk(clk),
		.en(en),
		.pix(pix),
		.hue_num(hue_num),
		.hue_den(hue_den),
		.sat_num(sat_num),
		.sat_den(sat_den),
		.defined(defined),
		.max_zero(max_zero)
	);

	rhsv_div #(
		.QW(HQW),
		.DW(CW),
		.SW(CW + 1),
		.STAGES(STAGES)
	) u_hue_div (
		.clk(clk),
		.en(en),
		.dividend(hue_num),
		.divisor(hue_den),
		.side_in({defined, sat_den}),
		.quotient(hue_quo),
		.side_out(hue_side)
	);

	rhsv_div #(
		.QW(SQW),
		.DW(CW),
		.SW(1),
		.STAGES(STAGES)
	) u_sat_div (
		.clk(clk),
		.en(en),
		.dividend(sat_num),
		.divisor(sat_den),
		.side_in(max_zero),
		.quotient(sat_quo),
		.side_out(sat_side)
	);

	always_comb begin
		hsv.hue_defined = hue_side[CW];
		hsv.brightness  = hue_side[CW-1:0];
		hsv.hue         = hue_side[CW] ? rhsv_pkg::hue_t'(hue_quo) : '0;
		hsv.saturation  = sat_side ? '0 : rhsv_pkg::sat_t'(sat_quo);
	end

endmodule

[tb/hsv_checker.sv]
`timescale 1ns / 1ps

module hsv_checker
	import rhsv_pkg::*;
#(
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	input  logic pix_stall,
	input  pix_t pix,
	input  logic hsv_valid,
	input  logic hsv_stall,
	input  hsv_t hsv,
	output int   mismatch_count,
	output int   pending_count
);

	hsv_t expected_hsv[$];

	function automatic hsv_t hsv_of_pixel(pix_t p);
		longint r, g, b, mx, mn, d, off, diff, t;
		hsv_t h;
		r = p.red;
		g = p.green;
		b = p.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		h = '0;
		h.brightness = chan_t'(mx);
		if (mx != 0)
			h.saturation = sat_t'((d << SAT_FRAC_BITS) / mx);
		if (d != 0) begin
			if (r == mx) begin
				off = 0;
				diff = g - b;
			end else if (g == mx) begin
				off = 2;
				diff = b - r;
			end else begin
				off = 4;
				diff = r - g;
			end
			t = 60 * (longint'(1) << HUE_FRAC_BITS) * (off * d + diff);
			if (t < 0)
				t += 360 * (longint'(1) << HUE_FRAC_BITS) * d;
			h.hue = hue_t'(t / d);
			h.hue_defined = 1'b1;
		end
		return h;
	endfunction

	assign pending_count = expected_hsv.size();

	initial mismatch_count = 0;

	always @(posedge clk) begin
		hsv_t want;
		if (arst_n) begin
			if (pix_valid && !pix_stall)
				expected_hsv.push_back(hsv_of_pixel(pix));
			if (hsv_valid && !hsv_stall) begin
				if (expected_hsv.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with no pixel waiting: hue %0d def %0b sat %0d val %0d",
							$realtime, hsv.hue, hsv.hue_defined, hsv.saturation,
							hsv.brightness);
					mismatch_count++;
				end else begin
					want = expected_hsv.pop_front();
					if (hsv.hue !== want.hue || hsv.hue_defined !== want.hue_defined ||
							hsv.saturation !== want.saturation ||
							hsv.brightness !== want.brightness) begin
						if (mismatch_count < 10)
							$display("%0t: expected hue %0d def %0b sat %0d val %0d, got hue %0d def %0b sat %0d val %0d",
								$realtime, want.hue, want.hue_defined, want.saturation,
								want.brightness, hsv.hue, hsv.hue_defined, hsv.saturation,
								hsv.brightness);
						mismatch_count++;
					end
				end
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import rhsv_pkg::*;

	localparam int HUE_FRAC_BITS = 6;
	localparam int SAT_FRAC_BITS = 12;
	localparam int PIXEL_COUNT   = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int STUCK_LIMIT   = 5000;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic hsv_valid;
	logic hsv_stall;
	hsv_t hsv;
	int   mismatch_count;
	int   pending_count;
	int   stuck_cycles;

	logic [23:0] corner_pixels [20] = '{
		24'h000000, 24'hffffff, 24'h808080, 24'h010101,
		24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
		24'h00ffff, 24'hff00ff, 24'hff0001, 24'h010000,
		24'hfffefe, 24'h010100, 24'h000101, 24'hff00fe,
		24'h00feff, 24'hfeff00, 24'hc86432, 24'h3264c8
	};

	rgb_to_hsv_converter #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.hsv_valid(hsv_valid),
		.hsv_stall(hsv_stall),
		.hsv(hsv)
	);

	hsv_checker #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_FRAC_BITS(SAT_FRAC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.hsv_valid(hsv_valid),
		.hsv_stall(hsv_stall),
		.hsv(hsv),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic chan_t edge_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		int pick;
		p = pix_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			p.green = p.red;
			p.blue = p.red;
		end else if (pick < 30) begin
			case ($urandom_range(0, 2))
				0: p.green = p.red;
				1: p.blue = p.green;
				default: p.blue = p.red;
			endcase
		end else if (pick < 40) begin
			p.red = edge_byte();
			p.green = edge_byte();
			p.blue = edge_byte();
		end
		return p;
	endfunction

	task automatic send_pixel(pix_t p, bit quiet);
		int gap;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
	endtask

	initial begin
		int n;
		hsv_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
			repeat (n) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				hsv_stall <= 1'b1;
				repeat (n) @(posedge clk);
				hsv_stall <= 1'b0;
			end
		end
	end

	initial stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (hsv_valid && !hsv_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (corner_pixels[k])
			send_pixel(pix_t'(corner_pixels[k]), 1'b0);
		for (int i = 0; i < PIXEL_COUNT; i++)
			send_pixel(random_pixel(), (i / 150) % 4 == 1);
		pix_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[rgb_to_hsv_converter.f]
src/rhsv_pkg.sv
src/rhsv_front.sv
src/rhsv_div.sv
src/rgb_to_hsv_converter.sv
tb/hsv_checker.sv
tb/testbench.sv
